>>> sv/dtfe_pkg.sv
// Shared types and constants for the drop-tail FIFO with ECN marking.
// No dependencies; imported by every module of the block.
`default_nettype none

package dtfe_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int CAP_W     = 9;
    localparam int OCC_W     = 9;
    localparam int DROP_W    = 32;
    localparam int DESC_IN_W = 32;
    localparam int STAT_W    = 2;

    localparam logic [CAP_W-1:0]  CAP_RESET = 9'd256;
    localparam logic [DROP_W-1:0] DROP_MAX  = 32'hFFFF_FFFF;

    // Operation selector on the input side
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_SENT     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Store access strobes from queue control to the packet store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

endpackage

`default_nettype wire

>>> sv/dtfe_store.sv
// Packet store: descriptor plus transport flag per slot, registered read.
// Depends on dtfe_pkg for the access strobe struct.
`default_nettype none

module dtfe_store #(
    parameter int DEPTH      = 256,
    parameter int DESC_WIDTH = 32
) (
    input  wire logic                      aclk,
    input  wire dtfe_pkg::mem_ctrl_t       mem_ctrl,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [DESC_WIDTH-1:0]     wr_desc,
    input  wire logic                      wr_trans,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [DESC_WIDTH-1:0]     rd_desc,
    output logic                           rd_trans
);
    import dtfe_pkg::*;

    localparam int ENTRY_W = DESC_WIDTH + 1;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Write the arriving entry at the tail
    always_ff @(posedge aclk) begin
        if (mem_ctrl.wr_en) begin
            mem[wr_addr] <= {wr_trans, wr_desc};
        end
    end

    // Read the head entry on a pop; hold it until the next pop
    always_ff @(posedge aclk) begin
        if (mem_ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_desc  = rd_data_reg[DESC_WIDTH-1:0];
    assign rd_trans = rd_data_reg[ENTRY_W-1];

endmodule

`default_nettype wire

>>> sv/dtfe_ctrl.sv
// Queue control: pointers, occupancy, drop counter and the per-transaction decision.
// Depends on dtfe_pkg for status codes, widths and the store strobe struct.
`default_nettype none

module dtfe_ctrl #(
    parameter int DEPTH = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            accept,
    input  wire logic                            op,
    input  wire logic [dtfe_pkg::CAP_W-1:0]      capacity,
    output dtfe_pkg::status_t                    status,
    output logic                                 over_thresh,
    output dtfe_pkg::mem_ctrl_t                  mem_ctrl,
    output logic [$clog2(DEPTH)-1:0]             wr_addr,
    output logic [$clog2(DEPTH)-1:0]             rd_addr,
    output logic [$clog2(DEPTH+1)-1:0]           count,
    output logic [dtfe_pkg::DROP_W-1:0]          drop_count
);
    import dtfe_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = ((CW > CAP_W) ? CW : CAP_W) + 3;
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [MW-1:0] DEPTH_M  = MW'(DEPTH);

    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DROP_W-1:0] drop_reg, drop_next;

    logic [MW-1:0] cap_m, cap_eff, count_m, left_m;
    logic          full, empty;

    // Clamp the configured capacity to the store depth
    always_comb begin
        cap_m   = MW'(capacity);
        cap_eff = (cap_m > DEPTH_M) ? DEPTH_M : cap_m;
        count_m = MW'(count_reg);
        left_m  = count_m - MW'(1);
    end

    assign full  = (count_m >= cap_eff);
    assign empty = (count_reg == '0);

    // Decide the transaction and the next queue state
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        drop_next   = drop_reg;
        status      = ST_EMPTY;
        mem_ctrl    = '0;
        over_thresh = 1'b0;
        if (op == OP_ARRIVAL) begin
            if (full) begin
                status = ST_DROPPED;
                if (drop_reg != DROP_MAX) begin
                    drop_next = drop_reg + DROP_W'(1);
                end
            end else begin
                status         = ST_ACCEPTED;
                mem_ctrl.wr_en = accept;
                tail_next      = (tail_reg == PTR_LAST) ? '0 : tail_reg + PW'(1);
                count_next     = count_reg + CW'(1);
            end
        end else begin
            if (!empty) begin
                status         = ST_SENT;
                mem_ctrl.rd_en = accept;
                head_next      = (head_reg == PTR_LAST) ? '0 : head_reg + PW'(1);
                count_next     = count_reg - CW'(1);
                // Mark when 5 * remaining exceeds 4 * capacity
                over_thresh    = ((left_m << 2) + left_m) > (cap_eff << 2);
            end
        end
    end

    // Advance queue state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            drop_reg  <= '0;
        end else if (accept) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    assign wr_addr    = tail_reg;
    assign rd_addr    = head_reg;
    assign count      = count_reg;
    assign drop_count = drop_reg;

    // Occupancy never exceeds the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        MW'(count_reg) <= DEPTH_M)
        else $error("occupancy above store depth");

    // A store write and a store read never happen together
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctrl.wr_en && mem_ctrl.rd_en))
        else $error("simultaneous store write and read");

    // Pointers and occupancy stay consistent: equal pointers mean empty or full
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == tail_reg) |-> (count_reg == '0 || MW'(count_reg) == DEPTH_M))
        else $error("pointers disagree with occupancy");

    // The drop counter never moves backward
    a_drop_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> drop_reg >= $past(drop_reg))
        else $error("drop counter decreased");

endmodule

`default_nettype wire

>>> sv/droptail_fifo_ecn_marker.sv
// Drop-tail packet FIFO with ECN marking; depends on dtfe_pkg, dtfe_ctrl, dtfe_store.
// Results are registered: each appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle unless a pending result is not taken; the result register
// frees whenever it is taken, and the store has one write and one registered read port.
// Reset (aresetn low, synchronous): queue empty, drop count zero, capacity 256,
// no result pending. Store contents are not cleared.
`default_nettype none

module droptail_fifo_ecn_marker #(
    parameter int DEPTH      = 256,
    parameter int DESC_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write: capacity
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dtfe_pkg::CAP_W-1:0]     cfg_data,
    // Input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,  // [31:0] packet_descriptor
    input  wire logic [1:0]                     s_tuser,  // [0] operation, [1] is_transport
    // Result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] departed_descriptor, [40:32] occupancy, [72:41] drop_count, [79:73] zero
    output logic [79:0]                         m_tdata,
    // [1:0] status, [2] departed_is_transport, [3] ecn_mark
    output logic [3:0]                          m_tuser
);
    import dtfe_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CAP_W-1:0]  capacity_reg;
    logic              m_valid_reg;
    status_t           status_reg;
    logic              thresh_reg;

    logic              accept;
    status_t           status;
    logic              over_thresh;
    mem_ctrl_t         mem_ctrl;
    logic [PW-1:0]     wr_addr, rd_addr;
    logic [CW-1:0]     count;
    logic [DROP_W-1:0] drop_count;
    logic [DESC_WIDTH-1:0] rd_desc;
    logic              rd_trans;
    logic              sent;

    // Capacity register, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    // Take a new transaction whenever the result register is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    dtfe_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .op          (s_tuser[0]),
        .capacity    (capacity_reg),
        .status      (status),
        .over_thresh (over_thresh),
        .mem_ctrl    (mem_ctrl),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .count       (count),
        .drop_count  (drop_count)
    );

    dtfe_store #(
        .DEPTH      (DEPTH),
        .DESC_WIDTH (DESC_WIDTH)
    ) u_store (
        .aclk     (aclk),
        .mem_ctrl (mem_ctrl),
        .wr_addr  (wr_addr),
        .wr_desc  (DESC_WIDTH'(s_tdata)),
        .wr_trans (s_tuser[1]),
        .rd_addr  (rd_addr),
        .rd_desc  (rd_desc),
        .rd_trans (rd_trans)
    );

    // Result register: valid flag under reset, payload loads on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status;
            thresh_reg <= over_thresh;
        end
    end

    // Queue state registers hold post-transaction values until the next accept
    assign sent     = (status_reg == ST_SENT);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0,
                       drop_count,
                       OCC_W'(count),
                       sent ? DESC_IN_W'(rd_desc) : {DESC_IN_W{1'b0}}};
    assign m_tuser  = {sent && rd_trans && thresh_reg,
                       sent && rd_trans,
                       status_reg};

endmodule

`default_nettype wire
